### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

### hdl/shs_pkg.sv
package shs_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controls for the message schedule line
  typedef struct packed {
    logic load_word;
    logic step;
  } sched_ctl_t;

  localparam logic       FUNC_ABSORB = 1'b0;
  localparam logic       FUNC_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_FILL    = 6'd56;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

### hdl/sha256_stream_hasher.sv
// An absorbed byte is taken while idle; a byte that fills a block also starts a compression
// (64 rounds of the shared round unit, then the hash update), during which input stalls.
// Finish: padding bytes, one or two compressions, then 8 output words.
// Long messages are bound by the single round unit: no byte is taken during a compression.
// Reset (synchronous, rst_n low): idle, initial hash loaded, fill and byte count zero.
module sha256_stream_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  shs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output shs_pkg::out_item_t  out_data
);
  import shs_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // takes items
  localparam logic [2:0] ST_PAD   = 3'd1;  // pushes padding bytes, one per cycle
  localparam logic [2:0] ST_ROUND = 3'd2;  // 64 compression rounds
  localparam logic [2:0] ST_FINAL = 3'd3;  // hash += working vars
  localparam logic [2:0] ST_OUT   = 3'd4;  // emits eight digest words

  logic [2:0]  state_r, state_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] v_r [8];        // working variables a..h
  logic [5:0]  round_r;
  logic [5:0]  fill_r;         // bytes held in the current block
  logic [60:0] msg_r;          // message byte count, wraps
  logic [63:0] len_r;          // bit length, shifted out MSB first
  logic [23:0] acc_r;          // partial word of the current block
  logic        pad_r;          // finish in progress
  logic        sent80_r;       // 0x80 marker already pushed
  logic        in_len_r;       // length bytes under way
  logic [2:0]  out_idx_r;

  logic        in_accept;
  logic        out_accept;
  logic        push_en;
  logic [7:0]  push_byte;
  logic        len_now;
  logic        block_done;
  sched_ctl_t  sched_ctl;
  logic [31:0] w_cur;
  logic [31:0] t1, t2;
  logic [31:0] ch, maj;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (state_r == ST_OUT);
  assign out_accept = out_valid && !out_stall;

  // Length bytes start once the padding reaches byte 56 after the marker, and
  // run for eight bytes, ending exactly on a block boundary.
  assign len_now = in_len_r || (sent80_r && (fill_r == LEN_FILL));

  always_comb begin
    push_en   = 1'b0;
    push_byte = in_data.data_byte;
    if (state_r == ST_IDLE && in_accept && in_data.func == FUNC_ABSORB) begin
      push_en = 1'b1;
    end else if (state_r == ST_PAD) begin
      push_en = 1'b1;
      if (!sent80_r) begin
        push_byte = PAD_BYTE;
      end else if (len_now) begin
        push_byte = len_r[63:56];
      end else begin
        push_byte = 8'h00;
      end
    end
  end

  assign block_done = push_en && (fill_r == 6'd63);

  // Bytes gather big-endian into words; every fourth byte shifts a word in.
  assign sched_ctl.load_word = push_en && (fill_r[1:0] == 2'b11);
  assign sched_ctl.step      = (state_r == ST_ROUND);

  shs_msg_sched u_sched (
    .clk     (clk),
    .ctl     (sched_ctl),
    .word_in ({acc_r, push_byte}),
    .w_out   (w_cur)
  );

  // One SHA-256 round, reused for all 64 rounds of a block.
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + bsig1(v_r[4]) + ch + round_k(round_r) + w_cur;
  assign t2  = bsig0(v_r[0]) + maj;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && in_data.func == FUNC_FINISH) state_nxt = ST_PAD;
        else if (block_done) state_nxt = ST_ROUND;
      end
      ST_PAD: begin
        if (block_done) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_r == 6'd63) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        // length bytes always close a block, so in_len_r here means done
        if (!pad_r) state_nxt = ST_IDLE;
        else if (in_len_r) state_nxt = ST_OUT;
        else state_nxt = ST_PAD;
      end
      ST_OUT: begin
        if (out_accept && out_idx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      msg_r     <= '0;
      pad_r     <= 1'b0;
      sent80_r  <= 1'b0;
      in_len_r  <= 1'b0;
      out_idx_r <= '0;
      round_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= init_h(3'(i));
      end
    end else begin
      state_r <= state_nxt;

      if (push_en) begin
        fill_r <= fill_r + 6'd1;
        acc_r  <= {acc_r[15:0], push_byte};
      end
      if (block_done) begin
        round_r <= '0;
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= hash_r[i];
        end
      end

      if (state_r == ST_IDLE && in_accept) begin
        if (in_data.func == FUNC_FINISH) begin
          len_r <= {msg_r, 3'b000};
          msg_r <= '0;
          pad_r <= 1'b1;
        end else begin
          msg_r <= msg_r + 61'd1;
        end
      end

      if (state_r == ST_PAD) begin
        sent80_r <= 1'b1;
        if (sent80_r && len_now) begin
          in_len_r <= 1'b1;
          len_r    <= {len_r[55:0], 8'h00};
        end
      end

      if (state_r == ST_ROUND) begin
        round_r <= round_r + 6'd1;
        v_r[0]  <= t1 + t2;
        v_r[1]  <= v_r[0];
        v_r[2]  <= v_r[1];
        v_r[3]  <= v_r[2];
        v_r[4]  <= v_r[3] + t1;
        v_r[5]  <= v_r[4];
        v_r[6]  <= v_r[5];
        v_r[7]  <= v_r[6];
      end

      if (state_r == ST_FINAL) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + v_r[i];
        end
      end

      // Last word taken: back to the initial state for the next message.
      if (out_accept) begin
        out_idx_r <= out_idx_r + 3'd1;
        if (out_idx_r == 3'd7) begin
          pad_r    <= 1'b0;
          sent80_r <= 1'b0;
          in_len_r <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            hash_r[i] <= init_h(3'(i));
          end
        end
      end
    end
  end

  // Digest words come straight from the hash registers, which hold while stalled.
  assign out_data.digest_word = hash_r[out_idx_r];
  assign out_data.word_index  = out_idx_r;
  assign out_data.last_word   = (out_idx_r == 3'd7);

endmodule

### hdl/shs_msg_sched.sv
// 16-word message line: loads block words, then expands W on each round.
module shs_msg_sched (
  input  logic               clk,
  input  shs_pkg::sched_ctl_t ctl,
  input  logic [31:0]        word_in,
  output logic [31:0]        w_out
);
  import shs_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] w_new;

  assign w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);
  assign w_out = w_r[0];

  always_ff @(posedge clk) begin
    if (ctl.load_word || ctl.step) begin
      for (int j = 0; j < 15; j++) begin
        w_r[j] <= w_r[j + 1];
      end
      w_r[15] <= ctl.load_word ? word_in : w_new;
    end
  end

endmodule

### hdl/shs_checker.sv
`include "assert_macros.svh"

module shs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input shs_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input shs_pkg::out_item_t out_data
);
  import shs_pkg::*;

  `SHS_ASSERT(a_busy_while_out, out_valid |-> in_stall, "input taken during digest output")
  `SHS_ASSERT_NEXT(a_byte_no_out, in_valid && !in_stall && in_data.func == FUNC_ABSORB, !out_valid, "byte item produced output")
  `SHS_ASSERT_NEXT(a_word_order, out_valid && !out_stall && !out_data.last_word, out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1, "digest words out of order")
  `SHS_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_data.last_word, !out_valid, "output after last word")
  `SHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled item changed")

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);

### test/tb.sv
module tb;
  import shs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  always #1 clk = ~clk;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // ---------------------------------------------------------------------------
  // Digest predictor: own copy of the hash state, byte buffer and length.
  // ---------------------------------------------------------------------------
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0] hstate [8];
  logic [7:0]  blk [64];
  logic [5:0]  blk_fill;
  logic [60:0] msg_len;
  out_item_t   digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_restart();
    foreach (hstate[i]) hstate[i] = SHA_IV[i];
    blk_fill = '0;
    msg_len = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hstate[0], hstate[1], hstate[2], hstate[3],
                                hstate[4], hstate[5], hstate[6], hstate[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hstate[0] += a; hstate[1] += b; hstate[2] += c; hstate[3] += d;
    hstate[4] += e; hstate[5] += f; hstate[6] += g; hstate[7] += h;
  endfunction

  function automatic void sha_push(logic [7:0] b);
    blk[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 0) sha_compress();
  endfunction

  // One accepted item: absorb a byte, or pad, flush and queue the eight digest words.
  function automatic void sha_predict(in_item_t it);
    logic [63:0] bit_len;
    out_item_t r;
    if (it.func == FUNC_ABSORB) begin
      sha_push(it.data_byte);
      msg_len++;
    end else begin
      bit_len = {msg_len, 3'b000};
      sha_push(PAD_BYTE);
      while (blk_fill != LEN_FILL) sha_push(8'h00);
      for (int i = 0; i < 8; i++) sha_push(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        r.digest_word = hstate[i];
        r.word_index = 3'(i);
        r.last_word = (i == 7);
        digest_q = {digest_q, r};
      end
      sha_restart();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue; pause markers make the sender wait for all digests.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t item;
    bit       drain;  // hold until nothing is outstanding, then send item
  } send_t;

  send_t send_q [$];
  int    err_cnt = 0;
  bit    stim_done = 1'b0;
  int    hold_off = 0;   // long receiver stall, counted down by the receiver-stall driver

  task automatic add_byte(logic [7:0] b);
    send_t s;
    s.item.func = FUNC_ABSORB; s.item.data_byte = b; s.drain = 1'b0;
    send_q = {send_q, s};
  endtask

  task automatic add_finish(logic [7:0] junk, bit drain);
    send_t s;
    s.item.func = FUNC_FINISH; s.item.data_byte = junk; s.drain = drain;
    send_q = {send_q, s};
  endtask

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    err_cnt++;
  endtask

  function automatic int short_or_long_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Input handshake as seen at the rising edge; the driver acts on it at the falling edge.
  bit in_took = 1'b0;
  always @(posedge clk) begin
    in_took = rst_n && in_valid && !in_stall;
  end

  // Driver: offers items at the falling edge; an accepted item is predicted at once.
  int gap = 0;
  bit no_gap_phase = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) sha_predict(in_data);
      if (!in_valid || in_took) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0 &&
                     !(send_q[0].drain && (digest_q.size() > 0 ||
                       (in_took && in_data.func == FUNC_FINISH)))) begin
          in_data <= send_q[0].item;
          in_valid <= 1'b1;
          void'(send_q.pop_front());
          gap <= no_gap_phase ? 0 : short_or_long_gap();
        end else begin
          in_valid <= 1'b0;
          in_data <= '{func: 1'($urandom_range(0, 1)), data_byte: 8'($urandom_range(0, 255))};
        end
      end
    end
  end

  // Receiver stall: random short/long, plus an explicit long hold-off.
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!no_gap_phase && $urandom_range(0, 3) == 0) rx_gap <= short_or_long_gap();
      end
    end
  end

  // Monitor: compare each accepted word against the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report("unexpected digest word", 32'd0, out_data.digest_word);
      end else begin
        e = digest_q.pop_front();
        if (out_data.digest_word !== e.digest_word)
          report("digest_word", e.digest_word, out_data.digest_word);
        if (out_data.word_index !== e.word_index)
          report("word_index", 32'(e.word_index), 32'(out_data.word_index));
        if (out_data.last_word !== e.last_word)
          report("last_word", 32'(e.last_word), 32'(out_data.last_word));
      end
    end
  end

  initial begin
    int n_items, len;
    sha_restart();
    // Directed: empty message (junk data on finish), one message of 00 and ff, "abc", then another empty one.
    add_finish(8'hff, 1'b0);
    add_byte(8'h00); add_byte(8'hff); add_finish(8'h00, 1'b0);
    add_byte(8'h61); add_byte(8'h62); add_byte(8'h63); add_finish(8'h5a, 1'b1);
    add_finish(8'h00, 1'b0);
    n_items = 0;
    // Random messages; lengths straddle the 55/56/63/64 padding boundaries at times.
    while (n_items < 100) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(54, 65);
        2: len = $urandom_range(66, 80);
        default: len = $urandom_range(0, 40);
      endcase
      for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)));
      add_finish(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      n_items += len + 1;
    end
    // Long message while the receiver holds off: block must back up its input.
    for (int i = 0; i < 60; i++) add_byte(8'($urandom_range(0, 255)));
    add_finish(8'h80, 1'b0);
    for (int i = 0; i < 3; i++) add_finish(8'($urandom_range(0, 255)), 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Stretch with no idling at all, then long receiver hold-off during traffic.
    no_gap_phase = 1'b1;
    repeat (300) @(posedge clk);
    no_gap_phase = 1'b0;
    hold_off = 2000;
    wait (send_q.size() == 0 && !in_valid);
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### sha256_stream_hasher.f
+incdir+hdl
hdl/shs_pkg.sv
hdl/shs_msg_sched.sv
hdl/sha256_stream_hasher.sv
hdl/shs_checker.sv
test/tb.sv
